>>> hdl/smet_pkg.sv
// ----------------------------------------------------------------------------
// Seed match extension tracker package
// Request and result types, configuration types and the codes shared by the
// tracker modules.
// ----------------------------------------------------------------------------
package smet_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_END_RUN        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MISMATCH_BLOCK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BLOCK_SEP      = 2'd2;

    localparam logic [7:0] MIN_END_RUN_RST        = 8'd10;
    localparam logic [7:0] MAX_MISMATCH_BLOCK_RST = 8'd3;
    localparam logic [7:0] MIN_BLOCK_SEP_RST      = 8'd20;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_COMPARE = 2'd1;
    localparam logic [1:0] MODE_END     = 2'd2;

    localparam logic [2:0] OC_CONT    = 3'd0;
    localparam logic [2:0] OC_MERGED  = 3'd1;
    localparam logic [2:0] OC_STOPPED = 3'd2;
    localparam logic [2:0] OC_SEQEND  = 3'd3;
    localparam logic [2:0] OC_IDLE    = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] seed_length;
        logic        identical;
        logic        reaches_target;
    } smet_in_t;

    typedef struct packed {
        logic [15:0] extend_by;
        logic [2:0]  outcome;
        logic        finished;
    } smet_out_t;

    typedef struct packed {
        logic [7:0] min_end_run;
        logic [7:0] max_mismatch_block;
        logic [7:0] min_block_sep;
    } smet_cfg_t;

endpackage

>>> hdl/smet_cfg_regs.sv
// ----------------------------------------------------------------------------
// Seed match extension tracker configuration registers
// Holds the three threshold registers written through the plain write port.
// ----------------------------------------------------------------------------
module smet_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smet_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    output smet_pkg::smet_cfg_t             cfg
);
    import smet_pkg::*;

    smet_cfg_t cfg_reg;
    smet_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_END_RUN:        cfg_next.min_end_run        = cfg_data;
                CFG_MAX_MISMATCH_BLOCK: cfg_next.max_mismatch_block = cfg_data;
                CFG_MIN_BLOCK_SEP:      cfg_next.min_block_sep      = cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_end_run        <= MIN_END_RUN_RST;
            cfg_reg.max_mismatch_block <= MAX_MISMATCH_BLOCK_RST;
            cfg_reg.min_block_sep      <= MIN_BLOCK_SEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/smet_core.sv
// ----------------------------------------------------------------------------
// Seed match extension tracker core
// Extension state and the combinational update that turns one request into
// its result.
// ----------------------------------------------------------------------------
module smet_core #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  smet_pkg::smet_in_t  item,
    input  smet_pkg::smet_cfg_t cfg,
    output smet_pkg::smet_out_t result
);
    import smet_pkg::*;

    localparam logic [32:0] LEN_MAX = (33'd1 << LEN_WIDTH) - 33'd1;

    logic [LEN_WIDTH-1:0] good_run_reg;
    logic [LEN_WIDTH-1:0] good_run_next;
    logic [LEN_WIDTH-1:0] pending_count_reg;
    logic [LEN_WIDTH-1:0] pending_count_next;
    logic [7:0]           recent_mismatches_reg;
    logic [7:0]           recent_mismatches_next;
    logic                 active_reg;
    logic                 active_next;

    logic [LEN_WIDTH-1:0] seed_sat;
    logic [LEN_WIDTH-1:0] good_inc;
    logic [LEN_WIDTH-1:0] pending_inc;
    logic [7:0]           mismatch_inc;
    logic [LEN_WIDTH-1:0] end_run;
    logic [LEN_WIDTH-1:0] block_sep;
    logic [32:0]          ext_wide;

    assign seed_sat     = ({17'd0, item.seed_length} > LEN_MAX) ? '1
                                                                : LEN_WIDTH'(item.seed_length);
    assign good_inc     = (&good_run_reg) ? good_run_reg : good_run_reg + 1'b1;
    assign pending_inc  = (&pending_count_reg) ? pending_count_reg : pending_count_reg + 1'b1;
    assign mismatch_inc = (&recent_mismatches_reg) ? recent_mismatches_reg
                                                   : recent_mismatches_reg + 8'd1;
    assign end_run      = LEN_WIDTH'(cfg.min_end_run);
    assign block_sep    = LEN_WIDTH'(cfg.min_block_sep);

    always_comb
    begin
        good_run_next          = good_run_reg;
        pending_count_next     = pending_count_reg;
        recent_mismatches_next = recent_mismatches_reg;
        active_next            = active_reg;
        ext_wide               = '0;
        result.outcome         = active_reg ? OC_CONT : OC_IDLE;
        result.finished        = 1'b0;

        case (item.mode)
            MODE_START:
            begin
                good_run_next          = seed_sat;
                pending_count_next     = '0;
                recent_mismatches_next = '0;
                active_next            = 1'b1;
                result.outcome         = OC_CONT;
            end
            MODE_COMPARE:
            begin
                if (active_reg)
                begin
                    if (item.identical)
                    begin
                        good_run_next = good_inc;
                        if (good_inc == block_sep)
                        begin
                            recent_mismatches_next = '0;
                        end
                        if (good_inc < end_run)
                        begin
                            pending_count_next = pending_inc;
                        end
                        else if (good_inc == end_run)
                        begin
                            ext_wide           = 33'(pending_count_reg) + 33'd1;
                            pending_count_next = '0;
                        end
                        else
                        begin
                            ext_wide = 33'd1;
                        end
                        if (item.reaches_target)
                        begin
                            result.outcome  = OC_MERGED;
                            result.finished = 1'b1;
                            active_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        good_run_next          = '0;
                        pending_count_next     = pending_inc;
                        recent_mismatches_next = mismatch_inc;
                        if (mismatch_inc > cfg.max_mismatch_block)
                        begin
                            result.outcome  = OC_STOPPED;
                            result.finished = 1'b1;
                            active_next     = 1'b0;
                        end
                    end
                end
            end
            MODE_END:
            begin
                if (active_reg)
                begin
                    ext_wide           = 33'(pending_count_reg);
                    pending_count_next = '0;
                    result.outcome     = OC_SEQEND;
                    result.finished    = 1'b1;
                    active_next        = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        result.extend_by = (ext_wide > 33'h0FFFF) ? 16'hFFFF : ext_wide[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_run_reg          <= '0;
            pending_count_reg     <= '0;
            recent_mismatches_reg <= '0;
            active_reg            <= 1'b0;
        end
        else if (fire)
        begin
            good_run_reg          <= good_run_next;
            pending_count_reg     <= pending_count_next;
            recent_mismatches_reg <= recent_mismatches_next;
            active_reg            <= active_next;
        end
    end

endmodule

>>> hdl/seed_match_extension_tracker.sv
// ----------------------------------------------------------------------------
// Seed match extension tracker
// Follows the ungapped extension of a seed match one base pair per request
// and reports how many bases to add to the match after each request.
// ----------------------------------------------------------------------------
//  Channel | Signals                          | Direction | Moves
//  in      | in_valid, in_stall, in_data      | into      | one request per accept
//  out     | out_valid, out_stall, out_data   | out of    | one result per request
//  cfg     | cfg_we, cfg_index, cfg_data      | into      | one register write
//
// One request is accepted every cycle when the result side keeps up.
// An accepted request is held in the request register, which feeds the update
// logic; its result is loaded into the result register when the request advances.
// Reset sets the tracker idle and loads the register defaults at once.
// A stalled result holds the result register, and the request register then
// stalls the input side after it fills.
// ----------------------------------------------------------------------------
module seed_match_extension_tracker #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  smet_pkg::smet_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output smet_pkg::smet_out_t              out_data,
    input  logic                             cfg_we,
    input  logic [smet_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);
    import smet_pkg::*;

    logic      in_full_reg;
    logic      in_full_next;
    smet_in_t  in_data_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    smet_out_t out_data_reg;
    logic      advance;
    logic      in_take;
    smet_cfg_t cfg;
    smet_out_t result;

    assign advance        = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_full_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign in_full_next   = in_take || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    smet_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smet_core #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/smet_checker.sv
// ----------------------------------------------------------------------------
// Seed match extension tracker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module smet_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input smet_pkg::smet_out_t out_data
);
    import smet_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled result changed or was dropped.");

    a_finish_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.finished |->
            (out_data.outcome == OC_MERGED || out_data.outcome == OC_STOPPED ||
             out_data.outcome == OC_SEQEND))
        else $error("Finished result carries a non-final outcome.");

    a_final_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome == OC_MERGED || out_data.outcome == OC_STOPPED ||
                      out_data.outcome == OC_SEQEND) |-> out_data.finished)
        else $error("Final outcome without the finished flag.");

    a_quiet_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.outcome == OC_IDLE || out_data.outcome == OC_STOPPED) |->
            out_data.extend_by == 16'd0)
        else $error("Idle or stopped result extends the match.");

endmodule

bind seed_match_extension_tracker smet_checker u_smet_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
